// ===== rtl/pedometer_dynamic_threshold_assert.svh =====
// ----------------------------------------------------------------------------
// Pedometer assertion macros
// Concurrent assertion wrappers clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef PEDOMETER_DYNAMIC_THRESHOLD_ASSERT_SVH
`define PEDOMETER_DYNAMIC_THRESHOLD_ASSERT_SVH

// check outside reset
`define PDT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check at every edge, reset included
`define PDT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/pdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Pedometer package
// Widths, reset values, register indexes and the configuration struct.
// ----------------------------------------------------------------------------
package pdt_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int AVG_DEPTH_DEF = 8;
    localparam int MIN_SWING_W   = 16;
    localparam int RANGE_W       = 10;
    localparam int COUNT_W       = 32;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;

    localparam logic [MIN_SWING_W-1:0] MIN_SWING_RST = 16'd2000;
    localparam logic [RANGE_W-1:0]     RANGE_RST     = 10'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWING = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 4'd1;

    typedef struct packed {
        logic [MIN_SWING_W-1:0] min_swing;
        logic [RANGE_W-1:0]     block_len;
    } cfg_t;

endpackage

// ===== rtl/pdt_cell.sv =====
// ----------------------------------------------------------------------------
// Pedometer history cell
// One tap of the sample history; loads the new sample or its neighbor's tap.
// ----------------------------------------------------------------------------
module pdt_cell (
    input  logic                                aclk,
    input  logic                                en,
    input  logic                                load_all,
    input  logic signed [pdt_pkg::SAMPLE_W-1:0] sample_in,
    input  logic signed [pdt_pkg::SAMPLE_W-1:0] prev_in,
    output logic signed [pdt_pkg::SAMPLE_W-1:0] tap
);

    logic signed [pdt_pkg::SAMPLE_W-1:0] tap_reg;
    logic signed [pdt_pkg::SAMPLE_W-1:0] tap_next;

    always_comb begin
        tap_next = tap_reg;
        if (en) begin
            tap_next = load_all ? sample_in : prev_in;
        end
    end

    always_ff @(posedge aclk) begin
        tap_reg <= tap_next;
    end

    assign tap = tap_reg;

endmodule

// ===== rtl/pdt_avg_chain.sv =====
// ----------------------------------------------------------------------------
// Pedometer moving-average chain
// Row of history cells and the running window sum.
// ----------------------------------------------------------------------------
module pdt_avg_chain #(
    parameter int AVG_DEPTH = pdt_pkg::AVG_DEPTH_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            en,
    input  logic signed [pdt_pkg::SAMPLE_W-1:0]             sample,
    output logic signed [pdt_pkg::SAMPLE_W+$clog2(AVG_DEPTH)-1:0] sum
);

    localparam int SUM_W = pdt_pkg::SAMPLE_W + $clog2(AVG_DEPTH);

    logic signed [pdt_pkg::SAMPLE_W-1:0] taps [AVG_DEPTH];
    logic                                primed_reg;
    logic                                primed_next;
    logic signed [SUM_W-1:0]             sum_reg;
    logic signed [SUM_W-1:0]             sum_next;
    logic signed [SUM_W-1:0]             s_ext;
    logic signed [SUM_W-1:0]             old_ext;
    logic signed [SUM_W-1:0]             depth_s;

    genvar g;
    generate
        for (g = 0; g < AVG_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                pdt_cell u_cell (
                    .aclk      (aclk),
                    .en        (en),
                    .load_all  (!primed_reg),
                    .sample_in (sample),
                    .prev_in   (sample),
                    .tap       (taps[g])
                );
            end else begin : g_body
                pdt_cell u_cell (
                    .aclk      (aclk),
                    .en        (en),
                    .load_all  (!primed_reg),
                    .sample_in (sample),
                    .prev_in   (taps[g-1]),
                    .tap       (taps[g])
                );
            end
        end
    endgenerate

    assign s_ext   = {{(SUM_W-pdt_pkg::SAMPLE_W){sample[pdt_pkg::SAMPLE_W-1]}}, sample};
    assign old_ext = {{(SUM_W-pdt_pkg::SAMPLE_W){taps[AVG_DEPTH-1][pdt_pkg::SAMPLE_W-1]}},
                      taps[AVG_DEPTH-1]};
    assign depth_s = SUM_W'(AVG_DEPTH);

    always_comb begin
        sum_next    = sum_reg;
        primed_next = primed_reg;
        if (en) begin
            primed_next = 1'b1;
            if (!primed_reg) begin
                sum_next = s_ext * depth_s;
            end else begin
                sum_next = sum_reg - old_ext + s_ext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
            sum_reg    <= '0;
        end else begin
            primed_reg <= primed_next;
            sum_reg    <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== rtl/pdt_detector.sv =====
// ----------------------------------------------------------------------------
// Pedometer range tracker and step detector
// Block max/min tracking, threshold latch and two-phase step detection.
// ----------------------------------------------------------------------------
module pdt_detector #(
    parameter int AVG_DEPTH = pdt_pkg::AVG_DEPTH_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            en,
    input  logic signed [pdt_pkg::SAMPLE_W+$clog2(AVG_DEPTH)-1:0] sum,
    input  pdt_pkg::cfg_t                                   cfg,
    output logic [pdt_pkg::COUNT_W-1:0]                     step_count,
    output logic                                            step_event
);

    localparam int SUM_W = pdt_pkg::SAMPLE_W + $clog2(AVG_DEPTH);

    localparam logic signed [SUM_W-1:0] MAX_RST = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] MIN_RST = {1'b0, {(SUM_W-1){1'b1}}};

    logic signed [SUM_W-1:0]         max_reg, max_next, max_upd;
    logic signed [SUM_W-1:0]         min_reg, min_next, min_upd;
    logic [pdt_pkg::RANGE_W-1:0]     cnt_reg, cnt_next, cnt_inc;
    logic signed [SUM_W:0]           mid_reg, mid_next;
    logic signed [SUM_W:0]           swing_reg, swing_next;
    logic                            await_reg, await_next;
    logic [pdt_pkg::COUNT_W-1:0]     steps_reg, steps_next;
    logic                            event_reg, event_next;
    logic                            latch;
    logic signed [SUM_W:0]           sum2;
    logic [SUM_W-1:0]                thr;
    logic                            fire;

    assign sum2 = {sum, 1'b0};
    assign thr  = SUM_W'(cfg.min_swing) * SUM_W'(AVG_DEPTH);

    always_comb begin
        max_upd    = (sum > max_reg) ? sum : max_reg;
        min_upd    = (sum < min_reg) ? sum : min_reg;
        cnt_inc    = cnt_reg + 1'b1;
        latch      = (cnt_inc >= cfg.block_len);
        max_next   = max_reg;
        min_next   = min_reg;
        cnt_next   = cnt_reg;
        mid_next   = mid_reg;
        swing_next = swing_reg;
        if (latch) begin
            mid_next   = (SUM_W+1)'(max_upd) + (SUM_W+1)'(min_upd);
            swing_next = (SUM_W+1)'(max_upd) - (SUM_W+1)'(min_upd);
        end
        fire       = !await_reg && (sum2 > mid_next) && (swing_next > $signed({1'b0, thr}));
        await_next = await_reg;
        steps_next = steps_reg;
        event_next = event_reg;
        if (en) begin
            max_next   = latch ? sum : max_upd;
            min_next   = latch ? sum : min_upd;
            cnt_next   = latch ? '0 : cnt_inc;
            event_next = fire;
            if (fire) begin
                steps_next = steps_reg + 1'b1;
                await_next = 1'b1;
            end else if (await_reg && (sum2 < mid_next)) begin
                await_next = 1'b0;
            end
        end else begin
            mid_next   = mid_reg;
            swing_next = swing_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg   <= MAX_RST;
            min_reg   <= MIN_RST;
            cnt_reg   <= '0;
            mid_reg   <= '0;
            swing_reg <= '0;
            await_reg <= 1'b0;
            steps_reg <= '0;
            event_reg <= 1'b0;
        end else begin
            max_reg   <= max_next;
            min_reg   <= min_next;
            cnt_reg   <= cnt_next;
            mid_reg   <= mid_next;
            swing_reg <= swing_next;
            await_reg <= await_next;
            steps_reg <= steps_next;
            event_reg <= event_next;
        end
    end

    assign step_count = steps_reg;
    assign step_event = event_reg;

endmodule

// ===== rtl/pedometer_dynamic_threshold.sv =====
// Pipeline: a sample transfer loads the window sum stage, and the detector
// stage then raises m_valid with the result for that sample.
// Throughput: one sample per cycle while m_ready is high; both stages
// advance together and hold while the output is stalled.
// Reset: synchronous active-low aresetn clears all control state, counters
// and the step total, and restores min_swing = 2000 and a block length of 50.
// ----------------------------------------------------------------------------
// Pedometer with dynamic threshold
// Moving-average filter over a chain of history cells, block max/min
// threshold tracking and a two-phase step counter.
// ----------------------------------------------------------------------------
`include "pedometer_dynamic_threshold_assert.svh"

module pedometer_dynamic_threshold #(
    parameter int AVG_DEPTH = pdt_pkg::AVG_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pdt_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pdt_pkg::COUNT_W-1:0]         m_step_count,
    output logic                                m_step_event,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pdt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pdt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SUM_W = pdt_pkg::SAMPLE_W + $clog2(AVG_DEPTH);

    pdt_pkg::cfg_t               cfg_reg, cfg_next;
    logic                        adv;
    logic                        in_xfer;
    logic                        det_en;
    logic                        v1_reg, v1_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0]     sum;
    logic [pdt_pkg::COUNT_W-1:0] step_total;
    logic [pdt_pkg::COUNT_W-1:0] step_inc;

    assign adv       = !out_valid_reg || m_ready;
    assign in_xfer   = s_valid && adv;
    assign det_en    = adv && v1_reg;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pdt_pkg::CFG_MIN_SWING: begin
                    cfg_next.min_swing = cfg_data[pdt_pkg::MIN_SWING_W-1:0];
                end
                pdt_pkg::CFG_BLOCK_LEN: begin
                    cfg_next.block_len = cfg_data[pdt_pkg::RANGE_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        v1_next        = v1_reg;
        out_valid_next = out_valid_reg;
        if (adv) begin
            v1_next        = s_valid;
            out_valid_next = v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_swing <= pdt_pkg::MIN_SWING_RST;
            cfg_reg.block_len <= pdt_pkg::RANGE_RST;
            v1_reg            <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            v1_reg        <= v1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    pdt_avg_chain #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (in_xfer),
        .sample  (s_sample),
        .sum     (sum)
    );

    pdt_detector #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_detector (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (det_en),
        .sum        (sum),
        .cfg        (cfg_reg),
        .step_count (step_total),
        .step_event (m_step_event)
    );

    assign m_step_count = step_total;
    assign step_inc     = {{(pdt_pkg::COUNT_W-1){1'b0}}, m_step_event};
    assign m_valid      = out_valid_reg;

    `PDT_ASSERT(a_count, det_en |=> step_total == $past(step_total) + step_inc, "step count jump")
    `PDT_ASSERT(a_ready_when_empty, (!m_valid) |-> s_ready, "input stalled with empty output")
    `PDT_ASSERT_ALWAYS(a_reset_clears_valid, (!aresetn) |=> (!m_valid), "output valid after reset")

endmodule

// ===== tb/sv/pdt_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Pedometer step count checker
// Tracks the filter, the threshold tracker and the step detector for every
// accepted sample. Holds the step results still owed by the block and checks
// each result against the oldest one.
// ----------------------------------------------------------------------------
package pdt_tb_pkg;

    import pdt_pkg::*;

    localparam int AVG_SHIFT = 3;
    localparam int AVG_DEPTH = 1 << AVG_SHIFT;
    localparam int SUM_W     = SAMPLE_W + AVG_SHIFT;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               stepped;
    } step_result_t;

    class step_count_checker;

        logic [MIN_SWING_W-1:0]     min_swing;
        logic [RANGE_W-1:0]         block_size;
        logic signed [SAMPLE_W-1:0] history [AVG_DEPTH];
        logic [AVG_SHIFT-1:0]       slot;
        logic signed [SUM_W-1:0]    sum;
        bit                         primed;
        logic signed [SUM_W-1:0]    peak;
        logic signed [SUM_W-1:0]    trough;
        logic [RANGE_W-1:0]         block_fill;
        logic signed [SUM_W:0]      mid2;
        logic signed [SUM_W:0]      swing;
        bit                         want_valley;
        logic [COUNT_W-1:0]         total;
        step_result_t               owed_steps [$];
        int                         errors;
        int                         samples;
        int                         events;
        int                         writes;

        function new();
            min_swing    = MIN_SWING_RST;
            block_size   = RANGE_RST;
            foreach (history[i]) history[i] = '0;
            slot         = '0;
            sum          = '0;
            primed       = 1'b0;
            peak         = {1'b1, {(SUM_W-1){1'b0}}};
            trough       = {1'b0, {(SUM_W-1){1'b1}}};
            block_fill   = '0;
            mid2         = '0;
            swing        = '0;
            want_valley  = 1'b0;
            total        = '0;
            errors       = 0;
            samples      = 0;
            events       = 0;
            writes       = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            writes++;
            if (idx == CFG_MIN_SWING) begin
                min_swing = data[MIN_SWING_W-1:0];
            end else if (idx == CFG_BLOCK_LEN) begin
                block_size = data[RANGE_W-1:0];
            end
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] s);
            logic signed [SUM_W:0]   sum2;
            logic signed [SUM_W+1:0] swing_wide;
            logic signed [SUM_W+1:0] swing_floor;
            step_result_t            r;
            if (!primed) begin
                foreach (history[i]) history[i] = s;
                sum    = {s, {AVG_SHIFT{1'b0}}};
                primed = 1'b1;
            end else begin
                sum           = sum - history[slot] + s;
                history[slot] = s;
                slot          = slot + 1'b1;
            end

            if (sum > peak) peak = sum;
            if (sum < trough) trough = sum;
            block_fill = block_fill + 1'b1;
            if (block_fill >= block_size) begin
                mid2       = peak + trough;
                swing      = peak - trough;
                peak       = sum;
                trough     = sum;
                block_fill = '0;
            end

            r.stepped   = 1'b0;
            sum2        = {sum, 1'b0};
            swing_wide  = swing;
            swing_floor = {2'b00, min_swing, {AVG_SHIFT{1'b0}}};
            if (!want_valley) begin
                if (sum2 > mid2 && swing_wide > swing_floor) begin
                    total       = total + 1'b1;
                    r.stepped   = 1'b1;
                    want_valley = 1'b1;
                end
            end else if (sum2 < mid2) begin
                want_valley = 1'b0;
            end
            r.count = total;
            owed_steps.push_back(r);
            samples++;
        endfunction

        function void complain(string what, longint unsigned want, longint unsigned got);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
        endfunction

        function void check_result(logic [COUNT_W-1:0] count, logic stepped);
            step_result_t want;
            if (stepped === 1'b1) events++;
            if (owed_steps.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("MISMATCH result with none owed: step_count %0d, step_event %0d",
                             count, stepped);
                return;
            end
            want = owed_steps.pop_front();
            if (count !== want.count) complain("step_count", want.count, count);
            if (stepped !== want.stepped) complain("step_event", want.stepped, stepped);
        endfunction

        function int pending();
            return owed_steps.size();
        endfunction

        function bit clean();
            return errors == 0 && owed_steps.size() == 0;
        endfunction

    endclass

endpackage

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Pedometer testbench
// Drives sample, result and register channels of the pedometer with bursty
// senders and a stalling receiver, walks several min_swing / block length
// settings, and checks every step result against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pdt_pkg::*;
    import pdt_tb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 4'd15;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 78;

    typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic signed [SAMPLE_W-1:0] s_sample  = '0;
    logic                       m_ready   = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;
    logic                       s_ready;
    logic                       m_valid;
    logic [COUNT_W-1:0]         m_step_count;
    logic                       m_step_event;
    logic                       cfg_ready;

    step_count_checker sb;

    int       burst_left   = 0;
    int       phases_run   = 0;
    int       stall_cycles = 0;
    rx_mode_t rx_mode      = RX_OPEN;
    int       rx_left      = 0;
    int       rx_tick      = 0;
    int       gait_k       = 0;
    int       gait_amp     = 8000;
    int       gait_period  = 20;
    int       gait_offset  = 0;
    int       gait_jitter  = 200;

    logic signed [SAMPLE_W-1:0] opening [11] = '{
        16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF,
        16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh5555, 16'shAAAA
    };
    logic signed [SAMPLE_W-1:0] square [12] = '{
        16'sd10000, 16'sd10000, 16'sd10000, 16'sd10000,
        -16'sd10000, -16'sd10000, -16'sd10000, -16'sd10000,
        16'sd10000, 16'sd10000, 16'sd10000, 16'sd10000
    };

    pedometer_dynamic_threshold u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_step_count (m_step_count),
        .m_step_event (m_step_event),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_step_count, m_step_event);
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(10, 80);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:     m_ready <= 1'b1;
                RX_RANDOM:   m_ready <= ($urandom_range(0, 9) < 7);
                RX_PERIODIC: m_ready <= (rx_tick % 5 != 0);
                default:     m_ready <= (rx_tick % 12 >= 8);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] next_gait();
        int t;
        int v;
        if ($urandom_range(0, 99) < 12) return SAMPLE_W'($urandom());
        t = gait_k % gait_period;
        gait_k++;
        v = (t < gait_period / 2) ? t : gait_period - t;
        v = gait_offset - gait_amp + (4 * gait_amp * v) / gait_period
            + int'($urandom_range(0, 2 * gait_jitter)) - gait_jitter;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SAMPLE_W'(v);
    endfunction

    task automatic pace();
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
        sb.take_sample(v);
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.apply_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] swing_floor,
                             input logic [CFG_DATA_W-1:0] block_len, input int n);
        quiesce();
        write_reg(CFG_MIN_SWING, swing_floor);
        write_reg(CFG_BLOCK_LEN, block_len);
        if ($urandom_range(0, 2) == 0) write_reg(CFG_IDX_TOP, CFG_DATA_W'($urandom()));
        gait_amp    = $urandom_range(500, 30000);
        gait_period = $urandom_range(8, 64);
        gait_offset = int'($urandom_range(0, 4000)) - 2000;
        gait_jitter = $urandom_range(0, 1500);
        phases_run++;
        repeat (n) begin
            pace();
            send_sample(next_gait());
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening[i]) begin
            pace();
            send_sample(opening[i]);
        end
        quiesce();
        write_reg(CFG_MIN_SWING, '0);
        write_reg(CFG_BLOCK_LEN, '0);
        write_reg(CFG_IDX_SPARE, 16'hFFFF);
        foreach (square[i]) begin
            pace();
            send_sample(square[i]);
        end

        run_phase(16'd2000, 16'd50, PHASE_ITEMS);
        run_phase(16'd0, 16'd1, PHASE_ITEMS);
        run_phase(16'hFFFF, 16'd1023, PHASE_ITEMS);
        run_phase(16'd300, 16'hFC14, PHASE_ITEMS);
        run_phase(16'd1500, 16'd25, PHASE_ITEMS);
        repeat (3)
            run_phase(CFG_DATA_W'($urandom_range(0, 4000)),
                      CFG_DATA_W'($urandom_range(1, 100)), PHASE_ITEMS);

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d samples, %0d register writes, %0d random phases, %0d steps",
                 sb.samples, sb.writes, phases_run, sb.events);
        $display("Final step total %0d, %0d mismatches", sb.total, sb.errors);
        if (sb.clean())
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pdt_pkg.sv
rtl/pdt_cell.sv
rtl/pdt_avg_chain.sv
rtl/pdt_detector.sv
rtl/pedometer_dynamic_threshold.sv
tb/sv/pdt_tb_pkg.sv
tb/sv/tb.sv
